>>> rtl/core/pft_pkg.sv
// Shared types, constants and controller/datapath signal groups for the
// Pareto front table. No dependencies.
package pft_pkg;

  localparam int CAPACITY  = 64;
  localparam int COST_BITS = 31;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    cost_t first;
    cost_t second;
  } entry_t;

  typedef enum logic [2:0] {
    REQ_QUERY  = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_RMWORS = 3'd2,
    REQ_PUSH   = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_READ   = 3'd5,
    REQ_CLEAR  = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    MODE_DOM    = 2'd0,
    MODE_WEAK   = 2'd1,
    MODE_STRICT = 2'd2,
    MODE_EQ     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOM,
    ST_CMP,
    ST_APPEND,
    ST_RD_ISSUE,
    ST_RD_CAP,
    ST_CLR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  scan;
    mode_t mode;
    logic  commit;
    logic  append;
    logic  rd_issue;
    logic  rd_cap;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic dom;
  } status_t;

endpackage

>>> rtl/core/pft_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on pft_pkg.
interface pft_in_if;
  import pft_pkg::*;
  logic  valid;
  logic  ready;
  logic [2:0] req_type;
  cost_t cost_first;
  cost_t cost_second;
  idx_t  read_index;
  modport source (output valid, req_type, cost_first, cost_second, read_index, input ready);
  modport sink   (input valid, req_type, cost_first, cost_second, read_index, output ready);
endinterface

interface pft_out_if;
  import pft_pkg::*;
  logic  valid;
  logic  ready;
  logic  is_dominated;
  logic  table_changed;
  logic  overflow;
  cnt_t  entry_count;
  logic  read_valid;
  cost_t read_first;
  cost_t read_second;
  modport source (output valid, is_dominated, table_changed, overflow, entry_count,
                  read_valid, read_first, read_second, input ready);
  modport sink   (input valid, is_dominated, table_changed, overflow, entry_count,
                  read_valid, read_first, read_second, output ready);
endinterface

>>> rtl/core/pareto_front_table.sv
// Top level of the Pareto front table: joins the request sequencer and the
// datapath. Depends on pft_pkg, pft_if, pft_ctrl and pft_datapath.
//
//  Channel   Direction  Handshake             Payload
//  in_ch     sink       valid/ready           req_type, cost_first, cost_second, read_index
//  out_ch    source     valid/ready           is_dominated, table_changed, overflow,
//                                             entry_count, read_valid, read_first, read_second
//
// One request is in flight at a time; in_ch.ready is high only while idle.
// A dominance scan or a compaction pass reads the stored entries in turn, since
// the single read port of the entry memory delivers one entry per cycle. An add
// that passes its check runs both passes and an append before its result beat;
// query, remove and a refused add run one pass, and push, clear, read and an
// unused request code run no pass.
// The next request can be taken in the cycle after the result beat.
// Reset empties the table at once; entry contents are not cleared.
// A result waits in its registers until out_ch.ready is seen; no new request
// is taken before that beat.
module pareto_front_table
  import pft_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  pft_in_if.sink  in_ch,
  pft_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  // The sequencer owns both handshakes and issues one command word per cycle.
  pft_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // The datapath holds the entries, the running flags and the result beat.
  pft_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_cost_first  (in_ch.cost_first),
    .in_cost_second (in_ch.cost_second),
    .in_read_index  (in_ch.read_index),
    .dom_o          (out_ch.is_dominated),
    .chg_o          (out_ch.table_changed),
    .ovf_o          (out_ch.overflow),
    .count_o        (out_ch.entry_count),
    .rv_o           (out_ch.read_valid),
    .rf_o           (out_ch.read_first),
    .rs_o           (out_ch.read_second)
  );

endmodule

>>> rtl/core/pft_datapath.sv
// Entry memory, scan pointers, compare logic and result registers.
// Depends on pft_pkg.
module pft_datapath
  import pft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output status_t    status,
  input  cost_t      in_cost_first,
  input  cost_t      in_cost_second,
  input  idx_t       in_read_index,
  output logic       dom_o,
  output logic       chg_o,
  output logic       ovf_o,
  output cnt_t       count_o,
  output logic       rv_o,
  output cost_t      rf_o,
  output cost_t      rs_o
);

  entry_t mem [CAPACITY];

  entry_t pair_r;
  idx_t   ridx_r;
  cnt_t   count_r, count_nxt;
  cnt_t   rd_ptr_r, rd_ptr_nxt;
  cnt_t   wr_ptr_r, wr_ptr_nxt;
  logic   pend_r, pend_nxt;
  entry_t rdata_r;
  logic   dom_r, dom_nxt;
  logic   chg_r, chg_nxt;
  logic   ovf_r, ovf_nxt;
  logic   rv_r, rv_nxt;
  cost_t  rf_r, rf_nxt;
  cost_t  rs_r, rs_nxt;

  logic   issue;
  idx_t   raddr;
  logic   we;
  idx_t   waddr;
  entry_t wdata;
  logic   e_dom_p, p_dom_e, eq, drop;

  // A stored entry that weakly dominates the pair, and the reverse.
  assign e_dom_p = (rdata_r.first <= pair_r.first) && (rdata_r.second <= pair_r.second);
  assign p_dom_e = (pair_r.first <= rdata_r.first) && (pair_r.second <= rdata_r.second);
  assign eq      = (pair_r.first == rdata_r.first) && (pair_r.second == rdata_r.second);

  always_comb begin
    unique case (cmd.mode)
      MODE_WEAK:   drop = p_dom_e;
      MODE_STRICT: drop = p_dom_e && !eq;
      MODE_EQ:     drop = eq;
      default:     drop = 1'b0;
    endcase
  end

  assign issue = cmd.scan && (rd_ptr_r < count_r);
  assign raddr = cmd.rd_issue ? ridx_r : rd_ptr_r[IDX_W-1:0];

  always_comb begin
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    pend_nxt   = pend_r;
    dom_nxt    = dom_r;
    chg_nxt    = chg_r;
    ovf_nxt    = ovf_r;
    rv_nxt     = rv_r;
    rf_nxt     = rf_r;
    rs_nxt     = rs_r;
    we         = 1'b0;
    waddr      = wr_ptr_r[IDX_W-1:0];
    wdata      = rdata_r;
    if (cmd.load) begin
      dom_nxt = 1'b0;
      chg_nxt = 1'b0;
      ovf_nxt = 1'b0;
      rv_nxt  = 1'b0;
      rf_nxt  = '0;
      rs_nxt  = '0;
    end
    if (cmd.start) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      pend_nxt   = 1'b0;
    end else if (cmd.scan) begin
      pend_nxt = issue;
      if (issue) begin
        rd_ptr_nxt = rd_ptr_r + cnt_t'(1);
      end
      if (pend_r) begin
        if (cmd.mode == MODE_DOM) begin
          if (e_dom_p) begin
            dom_nxt = 1'b1;
          end
        end else if (drop) begin
          chg_nxt = 1'b1;
        end else begin
          we         = 1'b1;
          wr_ptr_nxt = wr_ptr_r + cnt_t'(1);
        end
      end
    end
    if (cmd.commit) begin
      count_nxt = wr_ptr_r;
    end
    if (cmd.append) begin
      if (count_r < cnt_t'(CAPACITY)) begin
        we        = 1'b1;
        waddr     = count_r[IDX_W-1:0];
        wdata     = pair_r;
        count_nxt = count_r + cnt_t'(1);
        chg_nxt   = 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.rd_issue) begin
      rv_nxt = cnt_t'(ridx_r) < count_r;
    end
    if (cmd.rd_cap && rv_r) begin
      rf_nxt = rdata_r.first;
      rs_nxt = rdata_r.second;
    end
    if (cmd.clear) begin
      chg_nxt   = count_r != '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pair_r <= '{first: in_cost_first, second: in_cost_second};
      ridx_r <= in_read_index;
    end
    dom_r  <= dom_nxt;
    chg_r  <= chg_nxt;
    ovf_r  <= ovf_nxt;
    rv_r   <= rv_nxt;
    rf_r   <= rf_nxt;
    rs_r   <= rs_nxt;
    wr_ptr_r <= wr_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_ptr_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign status.scan_done = (rd_ptr_r == count_r) && !pend_r;
  assign status.dom       = dom_r;

  assign dom_o   = dom_r;
  assign chg_o   = chg_r;
  assign ovf_o   = ovf_r;
  assign count_o = count_r;
  assign rv_o    = rv_r;
  assign rf_o    = rf_r;
  assign rs_o    = rs_r;

endmodule

>>> rtl/core/pft_ctrl.sv
// Request sequencer: walks each request through its scan, compaction,
// append and read steps. Depends on pft_pkg.
module pft_ctrl
  import pft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  req_t   in_req;

  assign in_req = req_t'(in_req_type);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          unique case (in_req)
            REQ_QUERY, REQ_ADD, REQ_RMWORS: state_nxt = ST_DOM;
            REQ_PUSH:                       state_nxt = ST_APPEND;
            REQ_REMOVE:                     state_nxt = ST_CMP;
            REQ_READ:                       state_nxt = ST_RD_ISSUE;
            REQ_CLEAR:                      state_nxt = ST_CLR;
            default:                        state_nxt = ST_RESP;
          endcase
        end
      end
      ST_DOM: begin
        if (status.scan_done) begin
          if (req_r == REQ_QUERY || status.dom) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (status.scan_done) begin
          state_nxt = (req_r == REQ_ADD) ? ST_APPEND : ST_RESP;
        end
      end
      ST_APPEND:   state_nxt = ST_RESP;
      ST_RD_ISSUE: state_nxt = ST_RD_CAP;
      ST_RD_CAP:   state_nxt = ST_RESP;
      ST_CLR:      state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mode  = MODE_DOM;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.start = in_valid;
      end
      ST_DOM: begin
        cmd.scan  = ~status.scan_done;
        cmd.start = status.scan_done;
      end
      ST_CMP: begin
        cmd.scan = 1'b1;
        unique case (req_r)
          REQ_ADD:    cmd.mode = MODE_WEAK;
          REQ_RMWORS: cmd.mode = MODE_STRICT;
          default:    cmd.mode = MODE_EQ;
        endcase
        cmd.commit = status.scan_done;
      end
      ST_APPEND:   cmd.append   = 1'b1;
      ST_RD_ISSUE: cmd.rd_issue = 1'b1;
      ST_RD_CAP:   cmd.rd_cap   = 1'b1;
      ST_CLR:      cmd.clear    = 1'b1;
      ST_RESP:     out_valid    = 1'b1;
      default:     cmd.mode     = MODE_DOM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      req_r   <= REQ_NONE;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
    end
  end

endmodule

>>> rtl/core/pft_checker.sv
// Port-level checks for the Pareto front table, bound to the top level.
// Depends on pft_pkg.
module pft_checker
  import pft_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input logic  is_dominated,
  input logic  table_changed,
  input logic  overflow,
  input cnt_t  entry_count,
  input logic  read_valid,
  input cost_t read_first,
  input cost_t read_second
);

  // A held result keeps its count.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(entry_count))
    else $error("result beat changed while stalled");

  // No new request is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  // A dropped append only happens with a full table.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> entry_count == cnt_t'(CAPACITY))
    else $error("overflow without a full table");

  // A dominated pair never changes the table.
  a_dom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_dominated |-> !table_changed)
    else $error("dominated pair changed the table");

  // An out-of-range read returns zero costs.
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_valid |-> read_first == '0 && read_second == '0)
    else $error("read costs without a valid read");

endmodule

bind pareto_front_table pft_checker u_pft_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .is_dominated  (out_ch.is_dominated),
  .table_changed (out_ch.table_changed),
  .overflow      (out_ch.overflow),
  .entry_count   (out_ch.entry_count),
  .read_valid    (out_ch.read_valid),
  .read_first    (out_ch.read_first),
  .read_second   (out_ch.read_second)
);

>>> tb/sv/pft_scoreboard_pkg.sv
// Scoreboard for the Pareto front table testbench: a bit-true predictor of the
// table plus a queue of expected results. Depends on pft_pkg.
`timescale 1ns / 1ps
package pft_scoreboard_pkg;
  import pft_pkg::*;

  typedef struct packed {
    logic  is_dominated;
    logic  table_changed;
    logic  overflow;
    cnt_t  entry_count;
    logic  read_valid;
    cost_t read_first;
    cost_t read_second;
  } front_result_t;

  class front_scoreboard;
    entry_t        front[CAPACITY];
    int            live_count;
    front_result_t pending_results[$];
    int            error_count;

    function void clear_front();
      live_count = 0;
      pending_results.delete();
      error_count = 0;
    endfunction

    function bit dominated_by_front(cost_t c1, cost_t c2);
      for (int i = 0; i < live_count; i++)
        if (front[i].first <= c1 && front[i].second <= c2) return 1'b1;
      return 1'b0;
    endfunction

    // Drops entries that match the given rule and keeps the survivors in order.
    function bit prune(cost_t c1, cost_t c2, mode_t rule);
      int  kept;
      bit  changed;
      bit  drop;
      kept = 0;
      changed = 0;
      for (int i = 0; i < live_count; i++) begin
        if (rule == MODE_WEAK)
          drop = c1 <= front[i].first && c2 <= front[i].second;
        else if (rule == MODE_STRICT)
          drop = c1 <= front[i].first && c2 <= front[i].second &&
                 (front[i].first != c1 || front[i].second != c2);
        else
          drop = front[i].first == c1 && front[i].second == c2;
        if (drop) changed = 1;
        else begin
          front[kept] = front[i];
          kept++;
        end
      end
      live_count = kept;
      return changed;
    endfunction

    function bit append_pair(cost_t c1, cost_t c2);
      if (live_count >= CAPACITY) return 1'b0;
      front[live_count] = {c1, c2};
      live_count++;
      return 1'b1;
    endfunction

    function void note_request(logic [2:0] req, cost_t c1, cost_t c2, idx_t idx);
      front_result_t r;
      r = '0;
      case (req_t'(req))
        REQ_QUERY: r.is_dominated = dominated_by_front(c1, c2);
        REQ_ADD: begin
          if (dominated_by_front(c1, c2)) r.is_dominated = 1;
          else begin
            r.table_changed = prune(c1, c2, MODE_WEAK);
            if (append_pair(c1, c2)) r.table_changed = 1;
            else r.overflow = 1;
          end
        end
        REQ_RMWORS: begin
          if (dominated_by_front(c1, c2)) r.is_dominated = 1;
          else r.table_changed = prune(c1, c2, MODE_STRICT);
        end
        REQ_PUSH: begin
          if (append_pair(c1, c2)) r.table_changed = 1;
          else r.overflow = 1;
        end
        REQ_REMOVE: r.table_changed = prune(c1, c2, MODE_EQ);
        REQ_READ: begin
          if (idx < live_count) begin
            r.read_valid  = 1;
            r.read_first  = front[idx].first;
            r.read_second = front[idx].second;
          end
        end
        REQ_CLEAR: begin
          r.table_changed = live_count != 0;
          live_count = 0;
        end
        default: ;
      endcase
      r.entry_count = cnt_t'(live_count);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(front_result_t got, time stamp);
      front_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, got %h", stamp, got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch, expected dom=%0d chg=%0d ovf=%0d cnt=%0d rv=%0d rd=%0d,%0d",
                 stamp, want.is_dominated, want.table_changed, want.overflow,
                 want.entry_count, want.read_valid, want.read_first, want.read_second);
        $display("%0t:                  actual   dom=%0d chg=%0d ovf=%0d cnt=%0d rv=%0d rd=%0d,%0d",
                 stamp, got.is_dominated, got.table_changed, got.overflow,
                 got.entry_count, got.read_valid, got.read_first, got.read_second);
        error_count++;
      end
    endfunction
  endclass
endpackage

>>> tb/sv/pareto_front_table_test.sv
// Top-level testbench for pareto_front_table: drives random and directed
// requests, predicts every result and checks it. Depends on pft_pkg, pft_if
// and pft_scoreboard_pkg.
`timescale 1ns / 1ps
module pareto_front_table_test;
  import pft_pkg::*;
  import pft_scoreboard_pkg::*;

  localparam cost_t COST_MAX = '1;
  localparam int    RUN_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  pft_in_if  req_ch();
  pft_out_if res_ch();

  pareto_front_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  front_scoreboard board;

  // Idle percentages for each side; the stimulus process moves them per phase.
  int  send_idle_pct;
  int  recv_idle_pct;
  // When set, the receiver holds ready low for a long stretch of cycles.
  bit  hold_off_req;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: even with slow adds and stalls on the receiver, the run stays far
  // below the limit for its 1688 request beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Every beat on the request channel updates the predictor, every result beat
  // is checked against the oldest prediction. Both are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready)
      board.note_request(req_ch.req_type, req_ch.cost_first, req_ch.cost_second,
                         req_ch.read_index);
    if (rst_n && res_ch.valid && res_ch.ready)
      board.check_result({res_ch.is_dominated, res_ch.table_changed, res_ch.overflow,
                          res_ch.entry_count, res_ch.read_valid, res_ch.read_first,
                          res_ch.read_second}, $time);
  end

  // The receiver: ready changes at the falling edge only.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        for (stall = 0; stall < 400; stall++) @(negedge clk);
        hold_off_req = 0;
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request and keeps it up until the block takes it. Values change
  // at the falling edge only; valid stays high across back-to-back beats.
  task automatic send_request(input req_t req, input cost_t c1, input cost_t c2,
                              input idx_t idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= req;
    req_ch.cost_first  <= c1;
    req_ch.cost_second <= c2;
    req_ch.read_index  <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
  endtask

  // Costs mostly come from a narrow range so that dominance and equality hit
  // often; now and then a full-width value exercises the upper bits.
  function automatic cost_t pick_cost();
    case ($urandom_range(9))
      0: return cost_t'($urandom);
      1: return COST_MAX - cost_t'($urandom_range(3));
      default: return cost_t'($urandom_range(40));
    endcase
  endfunction

  // Weights favor add so that fronts build up; pushes fill the table to overflow.
  function automatic req_t pick_request();
    int w;
    w = $urandom_range(99);
    if (w < 35) return REQ_ADD;
    if (w < 47) return REQ_QUERY;
    if (w < 57) return REQ_RMWORS;
    if (w < 72) return REQ_PUSH;
    if (w < 80) return REQ_REMOVE;
    if (w < 95) return REQ_READ;
    if (w < 98) return REQ_CLEAR;
    return REQ_NONE;
  endfunction

  task automatic random_phase(input int count);
    req_t req;
    cost_t c1;
    cost_t c2;
    for (int n = 0; n < count; n++) begin
      req = pick_request();
      c1 = pick_cost();
      c2 = pick_cost();
      // Removes and worse-pruning removes often take stored costs so that they do something.
      if ((req == REQ_REMOVE || req == REQ_RMWORS) && board.live_count != 0 &&
          $urandom_range(1)) begin
        c1 = board.front[$urandom_range(board.live_count - 1)].first;
        c2 = board.front[$urandom_range(board.live_count - 1)].second;
      end
      send_request(req, c1, c2, idx_t'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.clear_front();
    cycle_count = 0;
    hold_off_req = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_NONE;
    req_ch.cost_first = '0;
    req_ch.cost_second = '0;
    req_ch.read_index = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: extremes, every request type and the listed corner cases.
    send_request(REQ_QUERY,  5, 5, 0);
    send_request(REQ_READ,   0, 0, 0);             // read of an empty table
    send_request(REQ_CLEAR,  0, 0, 0);             // clear when already empty
    send_request(REQ_ADD,    10, 20, 0);
    send_request(REQ_ADD,    20, 10, 0);
    send_request(REQ_ADD,    15, 25, 0);           // dominated add is refused
    send_request(REQ_QUERY,  10, 20, 0);           // equal pair is weakly dominated
    send_request(REQ_ADD,    COST_MAX, 0, 0);
    send_request(REQ_ADD,    0, COST_MAX, 0);
    send_request(REQ_PUSH,   30, 30, 0);
    send_request(REQ_PUSH,   30, 30, 0);
    send_request(REQ_REMOVE, 30, 30, 0);           // drops both equal entries
    send_request(REQ_RMWORS, 5, 5, 0);             // prunes strictly worse ones
    send_request(REQ_RMWORS, 5, 5, 0);             // no worse entries left, no change
    send_request(REQ_READ,   0, 0, 1);
    send_request(REQ_READ,   0, 0, 63);            // out of range
    send_request(REQ_NONE,   COST_MAX, COST_MAX, 63);
    send_request(REQ_ADD,    0, 0, 0);             // dominates everything
    send_request(REQ_CLEAR,  0, 0, 0);
    // Fill the table with pushes, then overflow both push and add.
    for (int i = 0; i < CAPACITY; i++)
      send_request(REQ_PUSH, cost_t'(100 + i), cost_t'(200 - i), idx_t'(i));
    send_request(REQ_PUSH,   1, 1, 0);
    send_request(REQ_ADD,    COST_MAX, 0, 0);      // full, nothing dominated
    send_request(REQ_ADD,    150, 150, 0);         // equals a stored entry, so it is refused
    send_request(REQ_READ,   0, 0, 63);
    send_request(REQ_CLEAR,  0, 0, 0);

    // Random phases with the idling patterns in turn.
    send_idle_pct = 24; recv_idle_pct = 75;
    random_phase(500);
    send_idle_pct = 75; recv_idle_pct = 24;
    random_phase(500);
    // Sender pauses until every expected result has come back.
    drain_results();
    send_idle_pct = 0; recv_idle_pct = 0;
    // Receiver holds off while requests keep coming, so the block backs up.
    hold_off_req = 1;
    random_phase(600);

    drain_results();
    repeat (200) @(negedge clk);
    if (board.error_count == 0 && board.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
